// File: design/lru_page_stack_update_defines.svh
// Assertion helpers for the LRU page stack.
`ifndef LRU_PAGE_STACK_UPDATE_DEFINES_SVH
`define LRU_PAGE_STACK_UPDATE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPSU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpsu check failed");

// Next-cycle implication, checked outside reset.
`define LPSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpsu sequencing check failed");

`endif

// File: design/lpsu_pkg.sv
`default_nettype none
package lpsu_pkg;

   localparam int PAGE_FIELD_W = 16;
   localparam int SLOT_FIELD_W = 3;

   typedef struct packed {
      logic [PAGE_FIELD_W-1:0] page;
      logic                    hit;
   } lpsu_req_type;

   typedef struct packed {
      logic [PAGE_FIELD_W-1:0] evicted_page;
      logic                    evicted_valid;
      logic [SLOT_FIELD_W-1:0] found_slot;
      logic                    treated_as_hit;
   } lpsu_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic update;
   } lpsu_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_full;
   } lpsu_status_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } lpsu_state_type;

endpackage
`default_nettype wire

// File: design/lru_page_stack_update.sv
// LRU page stack: keeps FRAMES resident page numbers, most recent in slot 0.
// Each request (page, hit) gives one response. A hit on a resident page moves
// it to the top and reports its slot; anything else pushes the page on top and
// drops the bottom slot, reporting it when it held a valid page. A request
// is handled in two steps: it is registered, then the parallel compare over all
// FRAMES slots and the shift of the stack are done. The next request is taken
// as soon as the update is done, even while the result still waits in the output
// register; the update only stalls while that register is full and not being
// taken. Reset clears the valid bits directly, with no clearing sequence.
`default_nettype none
`include "lru_page_stack_update_defines.svh"
module lru_page_stack_update #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire lpsu_pkg::lpsu_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output lpsu_pkg::lpsu_rsp_type      rsp_data
);
   import lpsu_pkg::*;

   lpsu_cmd_type    cmd;
   lpsu_status_type status;

   lpsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lpsu_datapath #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a transfer in puts the controller into the update step
   `LPSU_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // a moved hit never evicts
   `LPSU_ASSERT_NOW(a_hit_no_evict, clock, reset, rsp_valid && rsp_data.treated_as_hit, !rsp_data.evicted_valid)
   // slot and evicted page are zero unless they mean something
   `LPSU_ASSERT_NOW(a_miss_fields, clock, reset, rsp_valid && !rsp_data.treated_as_hit, rsp_data.found_slot == '0)
   `LPSU_ASSERT_NOW(a_evict_page, clock, reset, rsp_valid && !rsp_data.evicted_valid, rsp_data.evicted_page == '0)

endmodule
`default_nettype wire

// File: design/lpsu_ctrl.sv
`default_nettype none
module lpsu_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire lpsu_pkg::lpsu_status_type status,
   output lpsu_pkg::lpsu_cmd_type        cmd
);
   import lpsu_pkg::*;

   lpsu_state_type state_ff;
   lpsu_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.update  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // wait until the result register can take a new result
            if (!status.out_full) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: design/lpsu_datapath.sv
`default_nettype none
module lpsu_datapath #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lpsu_pkg::lpsu_req_type   req_data,
   input  wire lpsu_pkg::lpsu_cmd_type   cmd,
   output lpsu_pkg::lpsu_status_type     status,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output lpsu_pkg::lpsu_rsp_type        rsp_data
);
   import lpsu_pkg::*;

   logic [PAGE_BITS-1:0] hold_page_ff;
   logic                 hold_hit_ff;

   logic [PAGE_BITS-1:0] stack_pages_ff [FRAMES];
   logic [FRAMES-1:0]    stack_valid_ff;

   logic                 rsp_valid_ff;
   lpsu_rsp_type         rsp_data_ff;

   logic [FRAMES-1:0]    shift_mask;
   logic                 found;
   logic [SLOT_FIELD_W-1:0] slot_low;
   logic                 evict;
   lpsu_rsp_type         rsp_in;

   // Priority search from the top; shift_mask marks slots at or above the match
   // (all slots when nothing matches).
   always_comb begin
      found    = 1'b0;
      slot_low = '0;
      for (int i = 0; i < FRAMES; i++) begin
         shift_mask[i] = !found;
         if (!found && hold_hit_ff && stack_valid_ff[i] &&
             (stack_pages_ff[i] == hold_page_ff)) begin
            found    = 1'b1;
            slot_low = SLOT_FIELD_W'(i);
         end
      end
   end

   always_comb begin
      evict                 = !found && stack_valid_ff[FRAMES-1];
      rsp_in.evicted_valid  = evict;
      rsp_in.evicted_page   = evict ? PAGE_FIELD_W'(stack_pages_ff[FRAMES-1]) : '0;
      rsp_in.found_slot     = found ? slot_low : '0;
      rsp_in.treated_as_hit = found;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hold_page_ff <= PAGE_BITS'(req_data.page);
         hold_hit_ff  <= req_data.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         for (int i = 1; i < FRAMES; i++) begin
            if (shift_mask[i]) begin
               stack_pages_ff[i] <= stack_pages_ff[i-1];
            end
         end
         stack_pages_ff[0] <= hold_page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_valid_ff <= '0;
      end else if (cmd.update) begin
         for (int i = 1; i < FRAMES; i++) begin
            if (shift_mask[i]) begin
               stack_valid_ff[i] <= stack_valid_ff[i-1];
            end
         end
         stack_valid_ff[0] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.update) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign status.out_full = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule
`default_nettype wire

// File: sim/tb_lru_page_stack_update.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_lru_page_stack_update;
   import lpsu_pkg::*;

   localparam int FRAMES = 8;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   lpsu_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   lpsu_rsp_type rsp_data;

   lru_page_stack_update #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_FIELD_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // mirror of the recency stack, slot 0 = most recent
   logic [PAGE_FIELD_W-1:0] stk_page [FRAMES];
   logic                    stk_valid[FRAMES];

   lpsu_rsp_type evict_reports_q[$];

   bit idle_en;
   int errors;
   int n_refs;
   int n_moved;
   int n_evicts;
   int n_absent_hits;

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Applies one reference to the mirror stack, returns the report it causes.
   function automatic lpsu_rsp_type touch_stack(logic [PAGE_FIELD_W-1:0] page, logic hit);
      int           pos;
      int           i;
      lpsu_rsp_type r;
      pos = -1;
      r   = '0;
      if (hit) begin
         // scan bottom-up so the topmost match wins
         for (i = FRAMES - 1; i >= 0; i--) begin
            if (stk_valid[i] && stk_page[i] == page)
               pos = i;
         end
         if (pos < 0)
            n_absent_hits++;
      end
      if (pos >= 0) begin
         for (i = pos; i > 0; i--) begin
            stk_page[i]  = stk_page[i-1];
            stk_valid[i] = stk_valid[i-1];
         end
         r.found_slot     = pos[SLOT_FIELD_W-1:0];
         r.treated_as_hit = 1'b1;
         n_moved++;
      end else begin
         if (stk_valid[FRAMES-1]) begin
            r.evicted_page  = stk_page[FRAMES-1];
            r.evicted_valid = 1'b1;
            n_evicts++;
         end
         for (i = FRAMES - 1; i > 0; i--) begin
            stk_page[i]  = stk_page[i-1];
            stk_valid[i] = stk_valid[i-1];
         end
      end
      stk_page[0]  = page;
      stk_valid[0] = 1'b1;
      n_refs++;
      return r;
   endfunction

   // Drives one reference; valid stays high after the transfer so the next
   // call can follow back to back.
   task automatic send_ref(input logic [PAGE_FIELD_W-1:0] page, input logic hit);
      int gap;
      gap = 0;
      if (idle_en && $urandom_range(0, 4) == 0)
         gap = $urandom_range(1, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{page: page, hit: hit};
      do @(posedge clock); while (!req_ready);
      evict_reports_q.push_back(touch_stack(page, hit));
   endtask

   // Mostly well-formed traffic: hits on resident pages and fresh misses,
   // with duplicates, absent hits and a small hot set mixed in.
   task automatic random_ref();
      int                      sel;
      int                      s;
      logic [PAGE_FIELD_W-1:0] page;
      logic                    hit;
      sel = $urandom_range(0, 99);
      s   = $urandom_range(0, FRAMES - 1);
      if (!stk_valid[s])
         s = 0;
      if (sel < 45) begin
         page = stk_page[s];
         hit  = 1'b1;
      end else if (sel < 70) begin
         page = PAGE_FIELD_W'($urandom_range(0, 16'hFFFF));
         hit  = 1'b0;
      end else if (sel < 80) begin
         page = stk_page[s];
         hit  = 1'b0;
      end else if (sel < 90) begin
         page = PAGE_FIELD_W'($urandom_range(0, 16'hFFFF));
         hit  = 1'b1;
      end else begin
         page = PAGE_FIELD_W'($urandom_range(0, 15));
         hit  = 1'($urandom_range(0, 1));
      end
      send_ref(page, hit);
   endtask

   // Hit on an empty stack (stack pages are not reset, only marked invalid), then fill
   // past capacity so the first eviction comes out of the bottom.
   task automatic test_empty_and_fill();
      send_ref(16'h0000, 1'b1);
      send_ref(16'hFFFF, 1'b0);
      send_ref(16'h8000, 1'b0);
      send_ref(16'h0001, 1'b0);
      send_ref(16'h5555, 1'b0);
      send_ref(16'hAAAA, 1'b0);
      send_ref(16'h7FFF, 1'b0);
      send_ref(16'h0002, 1'b0);
      send_ref(16'h1234, 1'b0);
   endtask

   task automatic test_hit_slots();
      int slots[8] = '{7, 0, 3, 6, 1, 5, 2, 4};
      foreach (slots[k])
         send_ref(stk_page[slots[k]], 1'b1);
   endtask

   // Miss on a resident page leaves two copies; the later hit must take
   // the upper one. Then a hit on an absent page with a full stack.
   task automatic test_dup_and_absent();
      logic [PAGE_FIELD_W-1:0] p;
      p = stk_page[4];
      send_ref(p, 1'b0);
      send_ref(16'h0F0F, 1'b0);
      send_ref(p, 1'b1);
      send_ref(16'hBEEF, 1'b1);
   endtask

   task automatic test_random_refs(input int count);
      idle_en = 1'b1;
      repeat (count) random_ref();
   endtask

   task automatic test_back_to_back(input int count);
      idle_en = 1'b0;
      repeat (count) random_ref();
   endtask

   // response side: random stalls while idle_en is set, then check each transfer
   int stall_left;
   lpsu_rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (evict_reports_q.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               errors++;
            end else begin
               want = evict_reports_q.pop_front();
               if (rsp_data.evicted_page !== want.evicted_page) begin
                  $display("%0t: evicted_page expected %h got %h", $time,
                           want.evicted_page, rsp_data.evicted_page);
                  errors++;
               end
               if (rsp_data.evicted_valid !== want.evicted_valid) begin
                  $display("%0t: evicted_valid expected %b got %b", $time,
                           want.evicted_valid, rsp_data.evicted_valid);
                  errors++;
               end
               if (rsp_data.found_slot !== want.found_slot) begin
                  $display("%0t: found_slot expected %0d got %0d", $time,
                           want.found_slot, rsp_data.found_slot);
                  errors++;
               end
               if (rsp_data.treated_as_hit !== want.treated_as_hit) begin
                  $display("%0t: treated_as_hit expected %b got %b", $time,
                           want.treated_as_hit, rsp_data.treated_as_hit);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      idle_en       = 1'b1;
      errors        = 0;
      n_refs        = 0;
      n_moved       = 0;
      n_evicts      = 0;
      n_absent_hits = 0;
      for (int i = 0; i < FRAMES; i++) begin
         stk_page[i]  = '0;
         stk_valid[i] = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_and_fill();
      test_hit_slots();
      test_dup_and_absent();
      test_random_refs(800);
      test_back_to_back(350);

      req_valid <= 1'b0;
      while (evict_reports_q.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);

      $display("Ran %0d page references: %0d moved to front, %0d evictions,",
               n_refs, n_moved, n_evicts);
      $display("%0d hits on absent pages, with and without idle cycles.", n_absent_hits);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d responses outstanding", evict_reports_q.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
`default_nettype wire

// File: files.f
+incdir+design
design/lpsu_pkg.sv
design/lpsu_ctrl.sv
design/lpsu_datapath.sv
design/lru_page_stack_update.sv
sim/tb_lru_page_stack_update.sv
